// ----- hdl/dmx_pkg.sv -----
// shared types and constants for the differential drive mixer
// no dependencies; used by every module of the block
`default_nettype none

package dmx_pkg;

	localparam int CMD_W   = 12;
	localparam int DB_W    = 10;
	localparam int ALPHA_W = 9;
	localparam int DIR_W   = 2;
	localparam int MAG_W   = 12;
	localparam int DUTY_W  = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
	localparam logic [DUTY_W-1:0]  DUTY_MAX  = 12'd4095;
	localparam int DIV_STEPS = DUTY_W;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd3;

	localparam logic [CMD_W-1:0]   CENTER_RST   = 12'd2048;
	localparam logic [DB_W-1:0]    DEADBAND_RST = 10'd64;
	localparam logic [CMD_W-1:0]   MAX_RST      = 12'd4095;
	localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd64;

	localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
	localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;
	localparam logic signed [DIR_W-1:0] DIR_STOP = 2'sb00;

	typedef struct packed {
		logic [CMD_W-1:0]   center;
		logic [DB_W-1:0]    deadband;
		logic [CMD_W-1:0]   maxv;
		logic [ALPHA_W-1:0] alpha;
	} dmx_cfg_t;

	typedef struct packed {
		logic load;
		logic mix;
		logic filt;
		logic scale;
		logic dinit;
		logic div_step;
		logic out_load;
	} dmx_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/differential_drive_mixer_with_smoothing_core.sv -----
// top level of the differential drive mixer with smoothing
// depends on dmx_pkg, dmx_regs, dmx_ctrl and dmx_datapath
//
// usage:
// - input channel (in_valid / in_stall) carries one throttle and steering
//   command per transaction; in_stall is high while an item is in progress
// - output channel (out_valid / out_stall) carries direction and duty for
//   both motors, one result transaction per input transaction
// - configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   center, deadband, max value and smoothing alpha; cfg_ready is always high,
//   writes belong to idle periods
// - a new input is taken only once the previous result has been loaded into
//   the output register, so the block works on one item at a time
// - the duty comes from the 12-step restoring divider that scales the
//   filtered magnitude to a duty, one quotient bit per cycle for both sides
// - while the receiver stalls, the finished result stays in the output
//   register and the next item is taken and computed up to its final step
// - reset clears the filter state to zero, loads the register defaults and
//   leaves no result pending
`default_nettype none

module differential_drive_mixer_with_smoothing_core #(
	parameter int DUTY_FULL_SCALE = 4095
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [dmx_pkg::CMD_W-1:0]          throttle_in,
	input  wire logic [dmx_pkg::CMD_W-1:0]          steering_in,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [dmx_pkg::DIR_W-1:0]        left_dir,
	output logic signed [dmx_pkg::DIR_W-1:0]        right_dir,
	output logic [dmx_pkg::DUTY_W-1:0]              left_pwm,
	output logic [dmx_pkg::DUTY_W-1:0]              right_pwm,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [dmx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dmx_pkg::CFG_DAT_W-1:0]      cfg_data
);

	dmx_pkg::dmx_cfg_t cfg;
	dmx_pkg::dmx_cmd_t cmd;
	logic              busy;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;

	dmx_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dmx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.busy      (busy),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	dmx_datapath #(
		.DUTY_FULL_SCALE (DUTY_FULL_SCALE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.throttle_in (throttle_in),
		.steering_in (steering_in),
		.left_dir    (left_dir),
		.right_dir   (right_dir),
		.left_pwm    (left_pwm),
		.right_pwm   (right_pwm)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted but block not busy next cycle");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in progress");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_dir != 2'sb10 && right_dir != 2'sb10))
		else $error("illegal direction code on output");
`endif

endmodule

`default_nettype wire

// ----- hdl/dmx_regs.sv -----
// configuration register file: center, deadband, max value, smoothing alpha
// depends on dmx_pkg
`default_nettype none

module dmx_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [dmx_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [dmx_pkg::CFG_DAT_W-1:0]  wr_data,
	output dmx_pkg::dmx_cfg_t                   cfg
);

	dmx_pkg::dmx_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center   <= dmx_pkg::CENTER_RST;
			cfg_q.deadband <= dmx_pkg::DEADBAND_RST;
			cfg_q.maxv     <= dmx_pkg::MAX_RST;
			cfg_q.alpha    <= dmx_pkg::ALPHA_RST;
		end else if (wr_en) begin
			case (wr_index)
				dmx_pkg::REG_CENTER:   cfg_q.center   <= wr_data[dmx_pkg::CMD_W-1:0];
				dmx_pkg::REG_DEADBAND: cfg_q.deadband <= wr_data[dmx_pkg::DB_W-1:0];
				dmx_pkg::REG_MAX:      cfg_q.maxv     <= wr_data[dmx_pkg::CMD_W-1:0];
				dmx_pkg::REG_ALPHA:    cfg_q.alpha    <= wr_data[dmx_pkg::ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/dmx_ctrl.sv -----
// sequencing state machine: mix, filter, scale, divide, output handshake
// depends on dmx_pkg
`default_nettype none

module dmx_ctrl (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     out_stall,
	output logic          busy,
	output logic          out_valid,
	output dmx_pkg::dmx_cmd_t cmd
);

	localparam int CNT_W = $clog2(dmx_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(dmx_pkg::DIV_STEPS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MIX   = 3'd1;
	localparam logic [2:0] ST_FILT  = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_DINIT = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MIX;
				end
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_FILT;
			end
			ST_FILT: begin
				cmd.filt = 1'b1;
				state_d  = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.dinit = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- hdl/dmx_datapath.sv -----
// two-lane datapath: recentre, deadband, mix, smoothing filter, duty divider
// depends on dmx_pkg; driven by commands from dmx_ctrl
`default_nettype none

module dmx_datapath #(
	parameter int DUTY_FULL_SCALE = 4095
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dmx_pkg::dmx_cfg_t                  cfg,
	input  wire dmx_pkg::dmx_cmd_t                  cmd,
	input  wire logic [dmx_pkg::CMD_W-1:0]          throttle_in,
	input  wire logic [dmx_pkg::CMD_W-1:0]          steering_in,
	output logic signed [dmx_pkg::DIR_W-1:0]        left_dir,
	output logic signed [dmx_pkg::DIR_W-1:0]        right_dir,
	output logic [dmx_pkg::DUTY_W-1:0]              left_pwm,
	output logic [dmx_pkg::DUTY_W-1:0]              right_pwm
);

	localparam int MAG_W = dmx_pkg::MAG_W;
	localparam int DFS_W = $clog2(DUTY_FULL_SCALE + 1);
	localparam int PW    = dmx_pkg::DUTY_W + DFS_W;
	localparam int CMP_W = (DFS_W > MAG_W) ? DFS_W : MAG_W;
	localparam logic [DFS_W-1:0] DFS_V = DFS_W'(DUTY_FULL_SCALE);

	logic [dmx_pkg::CMD_W-1:0]          thr_q, str_q;
	logic signed [dmx_pkg::DIR_W-1:0]   dir_q [2];
	logic [MAG_W-1:0]                   mag_q [2];
	logic [MAG_W-1:0]                   smooth_q [2];
	logic [PW-1:0]                      prod_q [2];
	logic [MAG_W-1:0]                   rem_q [2];
	logic [dmx_pkg::DUTY_W-1:0]         dvd_q [2];
	logic [dmx_pkg::DUTY_W-1:0]         quot_q [2];
	logic                               sat_q [2];
	logic signed [dmx_pkg::DIR_W-1:0]   odir_q [2];
	logic [dmx_pkg::DUTY_W-1:0]         oduty_q [2];

	logic [MAG_W-1:0]              span;
	logic [dmx_pkg::ALPHA_W-1:0]   alpha;
	logic signed [13:0]            dbs, thr_c, str_c, thr_d, str_d;
	logic signed [13:0]            mix [2];
	logic [15:0]                   side [2];
	logic signed [12:0]            diff [2];
	logic signed [22:0]            fprod [2];
	logic signed [14:0]            fsum [2];
	logic [CMP_W-1:0]              hi_ext [2];
	logic [13:0]                   trial [2];

	function automatic logic [15:0] side_calc(input logic signed [13:0] m,
	                                          input logic signed [13:0] db,
	                                          input logic [MAG_W-1:0] sp);
		logic [13:0]       a;
		logic signed [1:0] d;
		if (m > db) begin
			d = dmx_pkg::DIR_FWD;
			a = $unsigned(m);
		end else if (m < -db) begin
			d = dmx_pkg::DIR_REV;
			a = $unsigned(-m);
		end else begin
			d = dmx_pkg::DIR_STOP;
			a = '0;
		end
		if (a > {2'b00, sp}) begin
			a = {2'b00, sp};
		end
		return {d, a};
	endfunction

	always_comb begin
		span  = (cfg.maxv > cfg.center) ? (cfg.maxv - cfg.center) : '0;
		alpha = (cfg.alpha > dmx_pkg::ALPHA_ONE) ? dmx_pkg::ALPHA_ONE : cfg.alpha;
		dbs   = $signed({4'b0000, cfg.deadband});
		thr_c = $signed({2'b00, thr_q}) - $signed({2'b00, cfg.center});
		str_c = $signed({2'b00, str_q}) - $signed({2'b00, cfg.center});
		thr_d = (thr_c > -dbs && thr_c < dbs) ? '0 : thr_c;
		str_d = (str_c > -dbs && str_c < dbs) ? '0 : str_c;
		mix[0] = thr_d + str_d;
		mix[1] = thr_d - str_d;
		for (int i = 0; i < 2; i++) begin
			side[i]   = side_calc(mix[i], dbs, span);
			diff[i]   = $signed({1'b0, mag_q[i]}) - $signed({1'b0, smooth_q[i]});
			fprod[i]  = $signed({1'b0, alpha}) * diff[i];
			fsum[i]   = $signed({3'b000, smooth_q[i]}) + 15'(fprod[i] >>> 8);
			hi_ext[i] = CMP_W'(prod_q[i][PW-1:dmx_pkg::DUTY_W]);
			trial[i]  = {1'b0, rem_q[i], dvd_q[i][dmx_pkg::DUTY_W-1]} - {2'b00, span};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q[0] <= '0;
			smooth_q[1] <= '0;
		end else if (cmd.filt) begin
			smooth_q[0] <= fsum[0][MAG_W-1:0];
			smooth_q[1] <= fsum[1][MAG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			thr_q <= throttle_in;
			str_q <= steering_in;
		end
		for (int i = 0; i < 2; i++) begin
			if (cmd.mix) begin
				dir_q[i] <= $signed(side[i][15:14]);
				mag_q[i] <= side[i][MAG_W-1:0];
			end
			if (cmd.scale) begin
				prod_q[i] <= PW'(smooth_q[i]) * PW'(DFS_V);
			end
			if (cmd.dinit) begin
				sat_q[i]  <= (hi_ext[i] >= CMP_W'(span));
				rem_q[i]  <= hi_ext[i][MAG_W-1:0];
				dvd_q[i]  <= prod_q[i][dmx_pkg::DUTY_W-1:0];
				quot_q[i] <= '0;
			end
			if (cmd.div_step) begin
				rem_q[i]  <= trial[i][13] ? {rem_q[i][MAG_W-2:0], dvd_q[i][dmx_pkg::DUTY_W-1]}
				                          : trial[i][MAG_W-1:0];
				quot_q[i] <= {quot_q[i][dmx_pkg::DUTY_W-2:0], ~trial[i][13]};
				dvd_q[i]  <= {dvd_q[i][dmx_pkg::DUTY_W-2:0], 1'b0};
			end
			if (cmd.out_load) begin
				odir_q[i] <= dir_q[i];
				if (span == '0) begin
					oduty_q[i] <= '0;
				end else if (sat_q[i]) begin
					oduty_q[i] <= dmx_pkg::DUTY_MAX;
				end else begin
					oduty_q[i] <= quot_q[i];
				end
			end
		end
	end

	assign left_dir  = odir_q[0];
	assign right_dir = odir_q[1];
	assign left_pwm  = oduty_q[0];
	assign right_pwm = oduty_q[1];

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// self-checking testbench for differential_drive_mixer_with_smoothing_core
// predicts direction and duty of both motors per command with its own mixer and filter
// depends on dmx_pkg and the core RTL
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dmx_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int FULL_SCALE = 4095;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_SETTING = 85;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic signed [DIR_W-1:0] left_dir;
		logic signed [DIR_W-1:0] right_dir;
		logic [DUTY_W-1:0]       left_pwm;
		logic [DUTY_W-1:0]       right_pwm;
	} motor_cmd_t;

	class mixer_scoreboard;
		dmx_cfg_t         cfg;
		logic [MAG_W-1:0] left_filt;
		logic [MAG_W-1:0] right_filt;
		motor_cmd_t       expected_q[$];
		int               mismatches;

		function new();
			cfg.center = CENTER_RST;
			cfg.deadband = DEADBAND_RST;
			cfg.maxv = MAX_RST;
			cfg.alpha = ALPHA_RST;
			left_filt = '0;
			right_filt = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_CENTER: cfg.center = data[CMD_W-1:0];
				REG_DEADBAND: cfg.deadband = data[DB_W-1:0];
				REG_MAX: cfg.maxv = data[CMD_W-1:0];
				REG_ALPHA: cfg.alpha = data[ALPHA_W-1:0];
				default: ;
			endcase
		endfunction

		function int deadband_zero(int v, int db);
			return (v > -db && v < db) ? 0 : v;
		endfunction

		function void mix_side(input int mixed, input int db, input int span,
			output logic signed [DIR_W-1:0] dir, output int mag);
			if (mixed > db) begin
				dir = DIR_FWD;
				mag = mixed;
			end else if (mixed < -db) begin
				dir = DIR_REV;
				mag = -mixed;
			end else begin
				dir = DIR_STOP;
				mag = 0;
			end
			if (mag > span)
				mag = span;
		endfunction

		function logic [MAG_W-1:0] lowpass(int x, logic [MAG_W-1:0] prev, int a);
			int y;
			y = (a * x + (int'(ALPHA_ONE) - a) * int'(prev)) >> 8;
			return y[MAG_W-1:0];
		endfunction

		function logic [DUTY_W-1:0] to_duty(logic [MAG_W-1:0] filt, int span);
			int d;
			if (span == 0)
				return '0;
			d = int'(filt) * FULL_SCALE / span;
			if (d > int'(DUTY_MAX))
				d = int'(DUTY_MAX);
			return d[DUTY_W-1:0];
		endfunction

		function void note_command(logic [CMD_W-1:0] thr, logic [CMD_W-1:0] str);
			int t, s, db, span, a, lmag, rmag;
			motor_cmd_t r;
			db = int'(cfg.deadband);
			t = deadband_zero(int'(thr) - int'(cfg.center), db);
			s = deadband_zero(int'(str) - int'(cfg.center), db);
			span = (cfg.maxv > cfg.center) ? int'(cfg.maxv) - int'(cfg.center) : 0;
			a = (cfg.alpha > ALPHA_ONE) ? int'(ALPHA_ONE) : int'(cfg.alpha);
			mix_side(t + s, db, span, r.left_dir, lmag);
			mix_side(t - s, db, span, r.right_dir, rmag);
			left_filt = lowpass(lmag, left_filt, a);
			right_filt = lowpass(rmag, right_filt, a);
			r.left_pwm = to_duty(left_filt, span);
			r.right_pwm = to_duty(right_filt, span);
			expected_q.push_back(r);
		endfunction

		function void check_result(motor_cmd_t got);
			motor_cmd_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with none expected: dir %0d/%0d duty %0d/%0d",
						$time, got.left_dir, got.right_dir, got.left_pwm, got.right_pwm);
				return;
			end
			want = expected_q.pop_front();
			if (got.left_dir !== want.left_dir || got.right_dir !== want.right_dir ||
				got.left_pwm !== want.left_pwm || got.right_pwm !== want.right_pwm) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"%0t: mismatch: expected dir %0d/%0d duty %0d/%0d,",
						" got dir %0d/%0d duty %0d/%0d"}, $time,
						want.left_dir, want.right_dir, want.left_pwm, want.right_pwm,
						got.left_dir, got.right_dir, got.left_pwm, got.right_pwm);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] throttle_in = '0;
	logic [CMD_W-1:0] steering_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DIR_W-1:0] left_dir;
	logic signed [DIR_W-1:0] right_dir;
	logic [DUTY_W-1:0] left_pwm;
	logic [DUTY_W-1:0] right_pwm;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	mixer_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	differential_drive_mixer_with_smoothing_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.throttle_in(throttle_in),
		.steering_in(steering_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_dir(left_dir),
		.right_dir(right_dir),
		.left_pwm(left_pwm),
		.right_pwm(right_pwm),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver: long hold-off when requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else
			out_stall <= (int'($urandom_range(99)) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_command(throttle_in, steering_in);
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{left_dir, right_dir, left_pwm, right_pwm});
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else if (++quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_command(input logic [CMD_W-1:0] thr, input logic [CMD_W-1:0] str);
		int gap;
		in_valid <= 1'b1;
		throttle_in <= thr;
		steering_in <= str;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		gap = 0;
		while (int'($urandom_range(99)) < send_idle_pct && gap < 200)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// let the clock advance first so the last accepted command is already noted
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_config(input logic [CFG_DAT_W-1:0] center, db, maxv, alpha);
		logic [CFG_IDX_W-1:0] idx[4];
		logic [CFG_DAT_W-1:0] data[4];
		idx = '{REG_CENTER, REG_DEADBAND, REG_MAX, REG_ALPHA};
		data = '{center, db, maxv, alpha};
		drain();
		foreach (idx[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= data[i];
			do
				@(posedge clk);
			while (!(cfg_valid && cfg_ready));
			sb.write_reg(idx[i], data[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config();
		logic [CFG_DAT_W-1:0] c, d, m, a;
		case ($urandom_range(9))
			0: c = '0;
			1: c = 12'hFFF;
			2, 3, 4: c = 12'd2048;
			default: c = CFG_DAT_W'($urandom);
		endcase
		case ($urandom_range(9))
			0: m = CFG_DAT_W'($urandom);
			1, 2, 3: m = c + CFG_DAT_W'($urandom_range(int'(12'hFFF - c)));
			default: m = 12'hFFF;
		endcase
		case ($urandom_range(5))
			0: d = '0;
			1: d = 12'h3FF;
			2: d = CFG_DAT_W'($urandom);
			default: d = CFG_DAT_W'($urandom_range(200));
		endcase
		d[CFG_DAT_W-1:DB_W] = (CFG_DAT_W-DB_W)'($urandom);
		case ($urandom_range(7))
			0: a = '0;
			1: a = 12'd256;
			2: a = CFG_DAT_W'($urandom_range(511));
			default: a = CFG_DAT_W'($urandom_range(255, 1));
		endcase
		a[CFG_DAT_W-1:ALPHA_W] = (CFG_DAT_W-ALPHA_W)'($urandom);
		write_config(c, d, m, a);
	endtask

	function automatic logic [CMD_W-1:0] pick_command();
		int v, db, c;
		db = int'(sb.cfg.deadband);
		c = int'(sb.cfg.center);
		case ($urandom_range(3))
			0: v = int'($urandom_range(4095));
			1: v = c + db + int'($urandom_range(2)) - 1;
			2: v = c - db + int'($urandom_range(2)) - 1;
			default: v = c + int'($urandom_range(2 * db + 400)) - db - 200;
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[CMD_W-1:0];
	endfunction

	task automatic directed_commands();
		send_command(12'd2048, 12'd2048);
		send_command(12'd2111, 12'd1985);
		send_command(12'd2112, 12'd2048);
		send_command(12'd2113, 12'd2048);
		send_command(12'd1983, 12'd2048);
		send_command(12'd2048, 12'd2148);
		send_command(12'd4095, 12'd2048);
		send_command(12'd4095, 12'd4095);
		send_command(12'd0, 12'd0);
		send_command(12'd0, 12'd4095);
		send_command(12'd4095, 12'd0);
		send_command(12'd2248, 12'd2248);
		// zero deadband, alpha beyond one saturates
		write_config(12'd0, 12'hC00, 12'hFFF, 12'h1FF);
		send_command(12'd0, 12'd0);
		send_command(12'd1, 12'd0);
		send_command(12'd4095, 12'd4095);
		send_command(12'd0, 12'd4095);
		// zero span at the top center
		write_config(12'hFFF, 12'h3FF, 12'hFFF, 12'h000);
		send_command(12'd0, 12'd0);
		send_command(12'd4095, 12'd0);
		// fill the filter, then shrink the span so the duty saturates
		write_config(12'd2048, 12'd0, 12'hFFF, 12'hF00);
		send_command(12'd4095, 12'd2048);
		write_config(12'd2048, 12'd0, 12'd2100, 12'd0);
		send_command(12'd2048, 12'd2048);
		// max below center
		write_config(12'd100, 12'h3FF, 12'd50, 12'd128);
		send_command(12'd4095, 12'd4095);
		send_command(12'd0, 12'd0);
	endtask

	initial begin
		int idle_pcts[4];
		int stall_pcts[4];
		idle_pcts = '{0, 87, 0, 17};
		stall_pcts = '{0, 0, 87, 17};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_commands();
		foreach (idle_pcts[p]) begin
			for (int half = 0; half < 2; half++) begin
				random_config();
				send_idle_pct = idle_pcts[p];
				stall_pct = stall_pcts[p];
				if (p == 0 && half == 0)
					hold_left = HOLD_CYCLES;
				repeat (ITEMS_PER_SETTING)
					send_command(pick_command(), pick_command());
			end
		end
		drain();
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/dmx_pkg.sv
hdl/dmx_regs.sv
hdl/dmx_ctrl.sv
hdl/dmx_datapath.sv
hdl/differential_drive_mixer_with_smoothing_core.sv
bench/tb.sv
